@@ hw/rtl/trse_pkg.sv @@
// ----------------------------------------------------------------------------
// trse_pkg
// Shared types and constants of the tile row span emitter.
// ----------------------------------------------------------------------------
package trse_pkg;

	localparam int unsigned TILE_PIXELS = 8;

	// Register indexes, taken from paddr[4:2].
	localparam logic [2:0] REG_SCREEN_SCALE = 3'd0;
	localparam logic [2:0] REG_TILE_SCALE   = 3'd1;
	localparam logic [2:0] REG_COLOR_ONE    = 3'd2;
	localparam logic [2:0] REG_COLOR_TWO    = 3'd3;
	localparam logic [2:0] REG_COLOR_THREE  = 3'd4;

	localparam logic [1:0] PIX_ONE = 2'd1;
	localparam logic [1:0] PIX_TWO = 2'd2;

	localparam logic [3:0] TILE_SCALE_MAX = 4'd8;

	typedef logic [TILE_PIXELS-1:0][1:0] pix_row_t;

	// Selection of the next coloured run of a row.
	typedef struct packed {
		logic       found;
		logic [2:0] start;
		logic [3:0] len;
		logic       last;
	} run_pick_t;

endpackage

@@ hw/rtl/tile_row_span_emitter.sv @@
// ----------------------------------------------------------------------------
// tile_row_span_emitter
// Turns a 2bpp tile row into coloured rectangles, one span per unstalled cycle.
// ----------------------------------------------------------------------------
// The first span of a row passes the input stage register, then the span output
// register. Spans leave at one per cycle while span_stall is low; a row holds
// the input stage until its last coloured run (at most eight) is emitted, and a
// fully transparent row leaves the input stage without emitting a span.
// Reset clears all valid flags; scales return to 1 and palette entries to 0.
module tile_row_span_emitter
	import trse_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [15:0]        row_bits,
	input  logic [2:0]         row_index,
	input  logic signed [11:0] base_x,
	input  logic signed [11:0] base_y,
	output logic               span_valid,
	input  logic               span_stall,
	output logic signed [13:0] rect_x,
	output logic signed [13:0] rect_y,
	output logic [7:0]         rect_width,
	output logic [4:0]         rect_height,
	output logic [23:0]        rect_color,
	output logic               last_span
);

	logic [1:0]  screen_scale_q;
	logic [3:0]  tile_scale_q;
	logic [23:0] color_one_q;
	logic [23:0] color_two_q;
	logic [23:0] color_three_q;

	logic [2:0]  reg_idx;
	logic        reg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_scale_q <= 2'd1;
			tile_scale_q   <= 4'd1;
			color_one_q    <= 24'd0;
			color_two_q    <= 24'd0;
			color_three_q  <= 24'd0;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_SCREEN_SCALE: screen_scale_q <= pwdata[1:0];
				REG_TILE_SCALE:   tile_scale_q   <= pwdata[3:0];
				REG_COLOR_ONE:    color_one_q    <= pwdata[23:0];
				REG_COLOR_TWO:    color_two_q    <= pwdata[23:0];
				REG_COLOR_THREE:  color_three_q  <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SCREEN_SCALE: prdata = {30'd0, screen_scale_q};
			REG_TILE_SCALE:   prdata = {28'd0, tile_scale_q};
			REG_COLOR_ONE:    prdata = {8'd0, color_one_q};
			REG_COLOR_TWO:    prdata = {8'd0, color_two_q};
			REG_COLOR_THREE:  prdata = {8'd0, color_three_q};
			default:          prdata = 32'd0;
		endcase
	end

	// Effective scales: zero counts as one, tile scale saturates at eight.
	logic [1:0] ss_eff;
	logic [3:0] ts_eff;
	logic [4:0] factor;

	assign ss_eff = (screen_scale_q == 2'd0) ? 2'd1 : screen_scale_q;
	always_comb begin
		if (tile_scale_q == 4'd0) begin
			ts_eff = 4'd1;
		end else if (tile_scale_q > TILE_SCALE_MAX) begin
			ts_eff = TILE_SCALE_MAX;
		end else begin
			ts_eff = tile_scale_q;
		end
	end
	assign factor = 5'(ss_eff) * 5'(ts_eff);

	// Input side: split pixels, mark run starts and work out the row origin.
	pix_row_t               pix_w;
	logic [TILE_PIXELS-1:0] bnd_w;
	logic [TILE_PIXELS-1:0] mask_w;
	logic signed [13:0]     ss_ext;
	logic signed [13:0]     ox_w;
	logic signed [13:0]     oy_w;
	logic [7:0]             row_off;

	always_comb begin
		for (int j = 0; j < TILE_PIXELS; j++) begin
			pix_w[j] = row_bits[2*(TILE_PIXELS-1-j) +: 2];
		end
		bnd_w[0] = 1'b1;
		for (int j = 1; j < TILE_PIXELS; j++) begin
			bnd_w[j] = (pix_w[j] != pix_w[j-1]);
		end
		for (int j = 0; j < TILE_PIXELS; j++) begin
			mask_w[j] = bnd_w[j] && (pix_w[j] != 2'd0);
		end
	end

	assign ss_ext  = $signed({12'd0, ss_eff});
	assign row_off = 8'(row_index) * 8'(factor);
	assign ox_w    = $signed({{2{base_x[11]}}, base_x}) * ss_ext;
	assign oy_w    = $signed({{2{base_y[11]}}, base_y}) * ss_ext
		+ $signed({6'd0, row_off});

	logic                   s1_valid_q;
	pix_row_t               pix_s1;
	logic [TILE_PIXELS-1:0] bnd_s1;
	logic [TILE_PIXELS-1:0] mask_s1;
	logic signed [13:0]     ox_s1;
	logic signed [13:0]     oy_s1;

	run_pick_t pick;

	trse_run_pick u_pick (
		.mask (mask_s1),
		.bnd  (bnd_s1),
		.pick (pick)
	);

	logic span_valid_q;
	logic out_free;
	logic emit;
	logic s1_done;
	logic accept;

	assign out_free   = !span_valid_q || !span_stall;
	assign emit       = s1_valid_q && pick.found && out_free;
	assign s1_done    = s1_valid_q && (!pick.found || (emit && pick.last));
	assign item_stall = s1_valid_q && !s1_done;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_done) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pix_w;
			bnd_s1  <= bnd_w;
			mask_s1 <= mask_w;
			ox_s1   <= ox_w;
			oy_s1   <= oy_w;
		end else if (emit) begin
			mask_s1[pick.start] <= 1'b0;
		end
	end

	// Span fields of the picked run.
	logic [1:0]         run_val;
	logic [7:0]         start_off;
	logic signed [13:0] rx_w;
	logic [7:0]         width_w;
	logic [23:0]        color_w;

	assign run_val   = pix_s1[pick.start];
	assign start_off = 8'(pick.start) * 8'(factor);
	assign rx_w      = ox_s1 + $signed({6'd0, start_off});
	assign width_w   = 8'(pick.len) * 8'(factor);

	always_comb begin
		case (run_val)
			PIX_ONE: color_w = color_one_q;
			PIX_TWO: color_w = color_two_q;
			default: color_w = color_three_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_valid_q <= 1'b0;
		end else if (emit) begin
			span_valid_q <= 1'b1;
		end else if (out_free) begin
			span_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rect_x      <= rx_w;
			rect_y      <= oy_s1;
			rect_width  <= width_w;
			rect_height <= factor;
			rect_color  <= color_w;
			last_span   <= pick.last;
		end
	end

	assign span_valid = span_valid_q;

	// A new row may only enter when the row in hand is finishing this cycle.
	a_accept_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s1_valid_q) |-> s1_done)
		else $error("row taken while previous row still has spans");

	// Each span beat retires exactly one pending run.
	a_mask_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !pick.last && !accept) |=>
		($countones(mask_s1) == $countones($past(mask_s1)) - 1))
		else $error("pending run mask did not shrink by one");

	// After the final span of a row, with no new row, the input stage is empty.
	a_empty_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && pick.last && !accept) |=> !s1_valid_q)
		else $error("input stage still busy after last span");

	// Presented spans are never degenerate.
	a_span_size: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid_q |-> ((rect_width != 8'd0) && (rect_height != 5'd0)))
		else $error("span with zero size");

endmodule

@@ hw/rtl/trse_run_pick.sv @@
// ----------------------------------------------------------------------------
// trse_run_pick
// Picks the lowest pending coloured run of a row and measures its length.
// ----------------------------------------------------------------------------
module trse_run_pick
	import trse_pkg::*;
(
	input  logic [TILE_PIXELS-1:0] mask,
	input  logic [TILE_PIXELS-1:0] bnd,
	output run_pick_t              pick
);

	logic [2:0] start;
	logic [3:0] endp;
	logic       found;
	logic [TILE_PIXELS-1:0] rest;

	always_comb begin
		found = 1'b0;
		start = 3'd0;
		for (int j = TILE_PIXELS - 1; j >= 0; j--) begin
			if (mask[j]) begin
				found = 1'b1;
				start = 3'(j);
			end
		end
	end

	// The run ends at the first boundary above its start, or at the row end.
	always_comb begin
		endp = 4'(TILE_PIXELS);
		for (int k = TILE_PIXELS - 1; k >= 1; k--) begin
			if (bnd[k] && (4'(k) > {1'b0, start})) begin
				endp = 4'(k);
			end
		end
	end

	always_comb begin
		rest = mask;
		rest[start] = 1'b0;
	end

	assign pick.found = found;
	assign pick.start = start;
	assign pick.len   = endp - {1'b0, start};
	assign pick.last  = (rest == '0);

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives tile rows into the span emitter and checks every span beat against
// an independent prediction of the run splitting, scaling and palette lookup.
// A short table of directed rows comes first, then phases of random rows under
// changing register settings, with random gaps on rows and stalls on spans.
// ----------------------------------------------------------------------------
module testbench;
	import trse_pkg::*;

	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_PHASES  = 8;
	localparam int ROWS_PER_PHASE = 58;

	// Indexes that decode to no register at all.
	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic signed [13:0] x;
		logic signed [13:0] y;
		logic [7:0]         w;
		logic [4:0]         h;
		logic [23:0]        color;
		logic               last;
	} span_t;

	typedef enum logic [1:0] {
		ROW_PREDICTED,
		ROW_EMPTY,
		ROW_SINGLE,
		REG_WRITE
	} step_kind_t;

	typedef struct packed {
		step_kind_t         kind;
		logic [15:0]        bits;
		logic [2:0]         row;
		logic signed [11:0] bx;
		logic signed [11:0] by;
		span_t              span;
		logic [2:0]         reg_idx;
		logic [31:0]        reg_value;
	} dir_step_t;

	localparam span_t NO_SPAN = '0;

	localparam dir_step_t DIRECTED [0:32] = '{
		'{ROW_EMPTY, 16'h0000, 3'd0, 12'sd0, 12'sd0, NO_SPAN, '0, '0},
		'{ROW_SINGLE, 16'h5555, 3'd0, 12'sd0, 12'sd0,
			'{14'sd0, 14'sd0, 8'd8, 5'd1, 24'h000000, 1'b1}, '0, '0},
		'{ROW_SINGLE, 16'hFFFF, 3'd7, 12'sd2047, 12'h800,
			'{14'sd2047, -14'sd2041, 8'd8, 5'd1, 24'h000000, 1'b1}, '0, '0},
		'{REG_WRITE, '0, '0, '0, '0, NO_SPAN, REG_COLOR_ONE, 32'h00FF0000},
		'{REG_WRITE, '0, '0, '0, '0, NO_SPAN, REG_COLOR_TWO, 32'h0000FF00},
		'{REG_WRITE, '0, '0, '0, '0, NO_SPAN, REG_COLOR_THREE, 32'h000000FF},
		'{ROW_SINGLE, 16'hAAAA, 3'd0, 12'h800, 12'sd2047,
			'{-14'sd2048, 14'sd2047, 8'd8, 5'd1, 24'h00FF00, 1'b1}, '0, '0},
		'{ROW_PREDICTED, 16'h1B1B, 3'd2, 12'sd100, -12'sd100, NO_SPAN, '0, '0},
		'{REG_WRITE, '0, '0, '0, '0, NO_SPAN, REG_SCREEN_SCALE, 32'd3},
		'{REG_WRITE, '0, '0, '0, '0, NO_SPAN, REG_TILE_SCALE, 32'd8},
		'{ROW_SINGLE, 16'hFFFF, 3'd7, 12'sd2047, 12'sd2047,
			'{14'sd6141, 14'sd6309, 8'd192, 5'd24, 24'h0000FF, 1'b1}, '0, '0},
		'{ROW_SINGLE, 16'hFFFF, 3'd7, 12'h800, 12'h800,
			'{-14'sd6144, -14'sd5976, 8'd192, 5'd24, 24'h0000FF, 1'b1}, '0, '0},
		'{ROW_PREDICTED, 16'hC000, 3'd0, -12'sd1, 12'sd1, NO_SPAN, '0, '0},
		'{ROW_PREDICTED, 16'h0003, 3'd5, 12'sd7, -12'sd7, NO_SPAN, '0, '0},
		'{ROW_PREDICTED, 16'h6666, 3'd3, -12'sd300, 12'sd300, NO_SPAN, '0, '0},
		'{ROW_PREDICTED, 16'h0FF0, 3'd1, 12'sd0, 12'sd0, NO_SPAN, '0, '0},
		'{ROW_PREDICTED, 16'h00FF, 3'd6, 12'sd12, 12'sd34, NO_SPAN, '0, '0},
		'{ROW_PREDICTED, 16'hFF00, 3'd4, -12'sd12, -12'sd34, NO_SPAN, '0, '0},
		'{ROW_PREDICTED, 16'h3FFC, 3'd2, 12'sd640, -12'sd480, NO_SPAN, '0, '0},
		'{ROW_EMPTY, 16'h0000, 3'd7, 12'sd2047, 12'sd2047, NO_SPAN, '0, '0},
		'{REG_WRITE, '0, '0, '0, '0, NO_SPAN, REG_SCREEN_SCALE, 32'd0},
		'{REG_WRITE, '0, '0, '0, '0, NO_SPAN, REG_TILE_SCALE, 32'd0},
		'{ROW_SINGLE, 16'h5555, 3'd3, 12'sd5, 12'sd5,
			'{14'sd5, 14'sd8, 8'd8, 5'd1, 24'hFF0000, 1'b1}, '0, '0},
		'{REG_WRITE, '0, '0, '0, '0, NO_SPAN, REG_SCREEN_SCALE, 32'd2},
		'{REG_WRITE, '0, '0, '0, '0, NO_SPAN, REG_TILE_SCALE, 32'd15},
		'{ROW_SINGLE, 16'hFFFF, 3'd1, 12'sd0, 12'sd0,
			'{14'sd0, 14'sd16, 8'd128, 5'd16, 24'h0000FF, 1'b1}, '0, '0},
		'{REG_WRITE, '0, '0, '0, '0, NO_SPAN, REG_TILE_SCALE, 32'd9},
		'{ROW_PREDICTED, 16'h4000, 3'd0, 12'sd1, 12'sd1, NO_SPAN, '0, '0},
		'{REG_WRITE, '0, '0, '0, '0, NO_SPAN, REG_SPARE_LO, 32'hFFFFFFFF},
		'{REG_WRITE, '0, '0, '0, '0, NO_SPAN, REG_SPARE_HI, 32'h00000000},
		'{ROW_SINGLE, 16'hFFFF, 3'd0, 12'sd0, 12'sd0,
			'{14'sd0, 14'sd0, 8'd128, 5'd16, 24'h0000FF, 1'b1}, '0, '0},
		'{REG_WRITE, '0, '0, '0, '0, NO_SPAN, REG_SCREEN_SCALE, 32'hFFFFFFFD},
		'{ROW_PREDICTED, 16'hE4E4, 3'd7, -12'sd1, -12'sd1, NO_SPAN, '0, '0}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic [15:0]        row_bits = '0;
	logic [2:0]         row_index = '0;
	logic signed [11:0] base_x = '0;
	logic signed [11:0] base_y = '0;
	logic               span_valid;
	logic               span_stall = 1'b0;
	logic signed [13:0] rect_x;
	logic signed [13:0] rect_y;
	logic [7:0]         rect_width;
	logic [4:0]         rect_height;
	logic [23:0]        rect_color;
	logic               last_span;

	// Shadow copy of the register file.
	logic [1:0]  shadow_screen = 2'd1;
	logic [3:0]  shadow_tile = 4'd1;
	logic [23:0] shadow_color_one = '0;
	logic [23:0] shadow_color_two = '0;
	logic [23:0] shadow_color_three = '0;

	span_t spans_pending [$];
	bit    no_idling = 1'b0;
	int    stall_left = 0;
	int    stuck_cycles = 0;
	int    mismatch_count = 0;
	int    rows_sent = 0;
	int    spans_checked = 0;
	int    settings_written = 0;

	tile_row_span_emitter dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.row_bits(row_bits),
		.row_index(row_index),
		.base_x(base_x),
		.base_y(base_y),
		.span_valid(span_valid),
		.span_stall(span_stall),
		.rect_x(rect_x),
		.rect_y(rect_y),
		.rect_width(rect_width),
		.rect_height(rect_height),
		.rect_color(rect_color),
		.last_span(last_span)
	);

	always #4 clk = ~clk;

	// Splits a row into runs and queues one span per coloured run. A span is
	// held back by one run so that the final one can carry the last mark.
	function automatic void derive_spans(input logic [15:0] bits, input logic [2:0] row,
			input logic signed [11:0] bx, input logic signed [11:0] by);
		pix_row_t   pix;
		int         ss;
		int         ts;
		int         factor;
		int         ox;
		int         oy;
		int         rx;
		int         start;
		int         len;
		logic [1:0] value;
		span_t      held;
		bit         have_held;
		pix = bits;
		ss = (shadow_screen == 2'd0) ? 1 : int'(shadow_screen);
		ts = (shadow_tile == 4'd0) ? 1 : int'(shadow_tile);
		if (ts > int'(TILE_SCALE_MAX))
			ts = int'(TILE_SCALE_MAX);
		factor = ss * ts;
		ox = bx * ss;
		oy = by * ss + int'(row) * factor;
		have_held = 1'b0;
		held = '0;
		start = 0;
		while (start < TILE_PIXELS) begin
			value = pix[TILE_PIXELS-1-start];
			len = 1;
			while (start + len < TILE_PIXELS && pix[TILE_PIXELS-1-start-len] == value)
				len++;
			if (value != 2'd0) begin
				if (have_held)
					spans_pending.push_back(held);
				rx = ox + start * factor;
				held.x = rx[13:0];
				held.y = oy[13:0];
				held.w = 8'(len * factor);
				held.h = 5'(factor);
				if (value == PIX_ONE)
					held.color = shadow_color_one;
				else if (value == PIX_TWO)
					held.color = shadow_color_two;
				else
					held.color = shadow_color_three;
				held.last = 1'b0;
				have_held = 1'b1;
			end
			start += len;
		end
		if (have_held) begin
			held.last = 1'b1;
			spans_pending.push_back(held);
		end
	endfunction

	// All tasks below start and end on a falling edge.
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		forever begin
			@(posedge clk);
			if (pready === 1'b1)
				break;
		end
		case (idx)
			REG_SCREEN_SCALE: shadow_screen = value[1:0];
			REG_TILE_SCALE:   shadow_tile = value[3:0];
			REG_COLOR_ONE:    shadow_color_one = value[23:0];
			REG_COLOR_TWO:    shadow_color_two = value[23:0];
			REG_COLOR_THREE:  shadow_color_three = value[23:0];
			default: ;
		endcase
		settings_written++;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Lets the block run dry, including any transparent row still in flight.
	task automatic wait_idle();
		item_valid = 1'b0;
		while (spans_pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic send_row(input step_kind_t kind, input logic [15:0] bits,
			input logic [2:0] row, input logic signed [11:0] bx,
			input logic signed [11:0] by, input span_t typed);
		int gap;
		gap = no_idling ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid = 1'b1;
		row_bits = bits;
		row_index = row;
		base_x = bx;
		base_y = by;
		forever begin
			@(posedge clk);
			if (item_stall === 1'b0)
				break;
		end
		case (kind)
			ROW_PREDICTED: derive_spans(bits, row, bx, by);
			ROW_SINGLE:    spans_pending.push_back(typed);
			default: ;
		endcase
		rows_sent++;
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			span_stall = 1'b1;
			stall_left--;
		end else begin
			span_stall = 1'b0;
		end
	end

	always @(posedge clk) begin
		span_t want;
		if (span_valid === 1'b1 && span_stall === 1'b0) begin
			stall_left = no_idling ? 0 : $urandom_range(0, 18);
			spans_checked++;
			if (spans_pending.size() == 0) begin
				$error("span beat with no span pending: x=%0d y=%0d", rect_x, rect_y);
				mismatch_count++;
			end else begin
				want = spans_pending.pop_front();
				if (rect_x !== want.x) begin
					$error("rect_x: expected %0d, got %0d", want.x, rect_x);
					mismatch_count++;
				end
				if (rect_y !== want.y) begin
					$error("rect_y: expected %0d, got %0d", want.y, rect_y);
					mismatch_count++;
				end
				if (rect_width !== want.w) begin
					$error("rect_width: expected %0d, got %0d", want.w, rect_width);
					mismatch_count++;
				end
				if (rect_height !== want.h) begin
					$error("rect_height: expected %0d, got %0d", want.h, rect_height);
					mismatch_count++;
				end
				if (rect_color !== want.color) begin
					$error("rect_color: expected %06h, got %06h", want.color, rect_color);
					mismatch_count++;
				end
				if (last_span !== want.last) begin
					$error("last_span: expected %0b, got %0b", want.last, last_span);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_stall === 1'b0) || (span_valid === 1'b1 && !span_stall)
				|| (psel && penable)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		dir_step_t          step;
		logic [15:0]        bits;
		logic [2:0]         row;
		logic signed [11:0] bx;
		logic signed [11:0] by;
		logic [1:0]         run_value;
		logic [1:0]         ss;
		logic [3:0]         ts;
		int                 pos;
		int                 run_len;
		int                 pick;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < $size(DIRECTED); i++) begin
			step = DIRECTED[i];
			if (step.kind == REG_WRITE) begin
				wait_idle();
				reg_write(step.reg_idx, step.reg_value);
			end else begin
				send_row(step.kind, step.bits, step.row, step.bx, step.by, step.span);
			end
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_idle();
			no_idling = (phase == 3 || phase == 6);
			case (phase)
				0: begin
					ss = 2'd1;
					ts = 4'd1;
				end
				1: begin
					ss = 2'd3;
					ts = 4'd8;
				end
				2: begin
					ss = 2'd0;
					ts = 4'd15;
				end
				default: begin
					ss = 2'($urandom_range(0, 3));
					ts = 4'($urandom_range(0, 15));
				end
			endcase
			reg_write(REG_SCREEN_SCALE, ($urandom() & ~32'h3) | 32'(ss));
			reg_write(REG_TILE_SCALE, ($urandom() & ~32'hF) | 32'(ts));
			if (phase == 1) begin
				reg_write(REG_COLOR_ONE, 32'hFFFFFFFF);
				reg_write(REG_COLOR_TWO, 32'h00FFFFFF);
				reg_write(REG_COLOR_THREE, 32'hFFFFFFFF);
			end else begin
				reg_write(REG_COLOR_ONE, $urandom());
				reg_write(REG_COLOR_TWO, $urandom());
				reg_write(REG_COLOR_THREE, $urandom());
			end
			if ($urandom_range(0, 1) == 1)
				reg_write(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom());

			for (int n = 0; n < ROWS_PER_PHASE; n++) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					bits = 16'h0000;
				end else if (pick < 4) begin
					bits = 16'($urandom());
				end else begin
					// Build the row from runs so that long runs turn up often.
					bits = '0;
					pos = 0;
					while (pos < TILE_PIXELS) begin
						run_len = $urandom_range(1, TILE_PIXELS - pos);
						run_value = 2'($urandom_range(0, 3));
						for (int k = 0; k < run_len; k++)
							bits[15-2*(pos+k) -: 2] = run_value;
						pos += run_len;
					end
				end
				row = 3'($urandom_range(0, 7));
				pick = $urandom_range(0, 7);
				bx = (pick == 0) ? 12'h800 : (pick == 1) ? 12'h7FF : 12'($urandom());
				pick = $urandom_range(0, 7);
				by = (pick == 0) ? 12'h800 : (pick == 1) ? 12'h7FF : 12'($urandom());
				send_row(ROW_PREDICTED, bits, row, bx, by, NO_SPAN);
			end
		end

		wait_idle();
		$display("Sent %0d tile rows and checked %0d span beats over %0d register writes.",
			rows_sent, spans_checked, settings_written);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
